@@ sv/assert_macros.svh @@
// Assertion macros shared by the extractor RTL.
// Needs nothing; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define DRE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication on every clock edge, reset included.
`define DRE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/dre_pkg.sv @@
// Types, constants and helpers for the DNS response address extractor.
// Used by the parser, the result queue and the top level.
package dre_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned RES_DEPTH = 4;
    localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
    localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_PORT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PAYLOAD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_WINDOW   = 2'd2;

    localparam logic [15:0] RESET_RESPONSE_PORT = 16'd53;
    localparam logic [15:0] RESET_MIN_PAYLOAD   = 16'd34;
    localparam logic [15:0] RESET_NAME_WINDOW   = 16'd512;

    localparam logic [7:0]  PTR_MARK  = 8'hc0;
    localparam logic [15:0] TYPE_A    = 16'd1;
    localparam logic [15:0] TYPE_MX   = 16'd15;
    localparam logic [15:0] CLASS_IN  = 16'd1;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [2:0] ST_COMPLETE  = 3'd0;
    localparam logic [2:0] ST_FILTERED  = 3'd1;
    localparam logic [2:0] ST_UNUSABLE  = 3'd2;
    localparam logic [2:0] ST_UNWANTED  = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [15:0] payload_length;
        logic [15:0] source_port;
        logic [31:0] client_address;
    } t_item;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] client_out;
        logic [31:0] server_address;
        logic [2:0]  end_status;
        logic        last_result;
    } t_result;

    typedef struct packed {
        logic    rec_valid;
        logic    status_valid;
        t_result rec;
        t_result status;
    } t_result_pair;

    function automatic logic dre_wanted(input logic [15:0] rtype, input logic [15:0] rclass);
        dre_wanted = (rclass == CLASS_IN) && ((rtype == TYPE_A) || (rtype == TYPE_MX));
    endfunction

endpackage

@@ sv/dre_parser.sv @@
// Per-byte DNS response parser: configuration registers, parse state and
// the single-pass update that yields up to two results per byte. Uses dre_pkg.
`include "assert_macros.svh"
module dre_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dre_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]                    i_cfg_data,
    input  logic                           i_step,
    input  dre_pkg::t_item                 i_item,
    output dre_pkg::t_result_pair          o_results
);
    import dre_pkg::*;

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_DONE       = 4'd1;
    localparam logic [3:0] PH_HEADER     = 4'd2;
    localparam logic [3:0] PH_NAME_LEN   = 4'd3;
    localparam logic [3:0] PH_NAME_LABEL = 4'd4;
    localparam logic [3:0] PH_NAME_PTR   = 4'd5;
    localparam logic [3:0] PH_QTYPE      = 4'd6;
    localparam logic [3:0] PH_ATYPE      = 4'd7;
    localparam logic [3:0] PH_ATTL       = 4'd8;
    localparam logic [3:0] PH_ARDLEN     = 4'd9;
    localparam logic [3:0] PH_ADDR       = 4'd10;
    localparam logic [3:0] PH_SKIP       = 4'd11;

    logic [15:0] r_cfg_port, r_cfg_min, r_cfg_window;

    logic [3:0]  r_phase, n_phase;
    logic [15:0] r_brem, n_brem;
    logic [3:0]  r_fpos, n_fpos;
    logic [7:0]  r_lab, n_lab;
    logic [15:0] r_ans, n_ans;
    logic [15:0] r_rd, n_rd;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_client, n_client;
    logic        r_rw, n_rw;
    logic [2:0]  r_stat, n_stat;

    logic        rec_v, st_v;
    logic [31:0] rec_server;
    logic [2:0]  st_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_port   <= RESET_RESPONSE_PORT;
            r_cfg_min    <= RESET_MIN_PAYLOAD;
            r_cfg_window <= RESET_NAME_WINDOW;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RESPONSE_PORT: r_cfg_port   <= i_cfg_data;
                CFG_MIN_PAYLOAD:   r_cfg_min    <= i_cfg_data;
                CFG_NAME_WINDOW:   r_cfg_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [15:0] rem;
        logic [7:0]  b;
        logic [15:0] rdlen;
        rem        = '0;
        b          = i_item.data_byte;
        rdlen      = '0;
        n_phase    = r_phase;
        n_brem     = r_brem;
        n_fpos     = r_fpos;
        n_lab      = r_lab;
        n_ans      = r_ans;
        n_rd       = r_rd;
        n_shift    = r_shift;
        n_client   = r_client;
        n_rw       = r_rw;
        n_stat     = r_stat;
        rec_v      = 1'b0;
        st_v       = 1'b0;
        rec_server = '0;
        st_code    = ST_COMPLETE;

        if (i_item.first_byte) begin
            n_client = i_item.client_address;
            n_brem   = i_item.payload_length;
            n_fpos   = '0;
            n_shift  = '0;
            n_lab    = '0;
            n_ans    = '0;
            n_rd     = '0;
            n_rw     = 1'b1;
            n_stat   = ST_COMPLETE;
            n_phase  = PH_HEADER;
            if (i_item.source_port != r_cfg_port || i_item.payload_length <= r_cfg_min) begin
                n_phase = PH_DONE;
                n_stat  = ST_FILTERED;
            end
        end

        if (n_phase != PH_IDLE) begin
            if (n_phase != PH_DONE) begin
                if (n_brem == 16'd0) begin
                    n_phase = PH_DONE;
                    n_stat  = ST_TRUNCATED;
                end else begin
                    n_brem = n_brem - 16'd1;
                    rem    = n_brem;
                    case (n_phase)
                        PH_HEADER: begin
                            if (n_fpos == 4'd2 && (!b[7] || b[6:3] != 4'd0)) n_rw = 1'b0;
                            if (n_fpos == 4'd3 && b[3:0] != 4'd0) n_rw = 1'b0;
                            if (n_fpos == 4'd6) n_shift = {24'd0, b};
                            if (n_fpos == 4'd7 && (!n_rw || {n_shift[7:0], b} == 16'd0)) begin
                                n_ans   = {n_shift[7:0], b};
                                n_phase = PH_DONE;
                                n_stat  = ST_UNUSABLE;
                            end else begin
                                if (n_fpos == 4'd7) n_ans = {n_shift[7:0], b};
                                if (n_fpos == 4'd11) begin
                                    n_fpos = '0;
                                    if (rem == 16'd0 || rem > r_cfg_window) begin
                                        n_phase = PH_DONE;
                                        n_stat  = ST_TRUNCATED;
                                    end else begin
                                        n_phase = PH_NAME_LEN;
                                    end
                                end else begin
                                    n_fpos = n_fpos + 4'd1;
                                end
                            end
                        end
                        PH_NAME_LEN: begin
                            if (b == 8'd0) begin
                                if (rem < 16'd4) begin
                                    n_phase = PH_DONE;
                                    n_stat  = ST_TRUNCATED;
                                end else begin
                                    n_phase = (n_fpos != 4'd0) ? PH_ATYPE : PH_QTYPE;
                                    n_fpos  = '0;
                                    n_shift = '0;
                                end
                            end else if (b == PTR_MARK) begin
                                if (rem < 16'd5) begin
                                    n_phase = PH_DONE;
                                    n_stat  = ST_TRUNCATED;
                                end else begin
                                    n_phase = PH_NAME_PTR;
                                end
                            end else if (rem <= {8'd0, b}) begin
                                n_phase = PH_DONE;
                                n_stat  = ST_TRUNCATED;
                            end else begin
                                n_lab   = b;
                                n_phase = PH_NAME_LABEL;
                            end
                        end
                        PH_NAME_LABEL: begin
                            n_lab = n_lab - 8'd1;
                            if (n_lab == 8'd0) n_phase = PH_NAME_LEN;
                        end
                        PH_NAME_PTR: begin
                            n_phase = (n_fpos != 4'd0) ? PH_ATYPE : PH_QTYPE;
                            n_fpos  = '0;
                            n_shift = '0;
                        end
                        PH_QTYPE: begin
                            n_shift = {n_shift[23:0], b};
                            n_fpos  = n_fpos + 4'd1;
                            if (n_fpos == 4'd4) begin
                                if (!dre_wanted(n_shift[31:16], n_shift[15:0])) begin
                                    n_phase = PH_DONE;
                                    n_stat  = ST_UNWANTED;
                                end else begin
                                    n_fpos = 4'd1;
                                    if (rem == 16'd0 || rem > r_cfg_window) begin
                                        n_phase = PH_DONE;
                                        n_stat  = ST_TRUNCATED;
                                    end else begin
                                        n_phase = PH_NAME_LEN;
                                    end
                                end
                            end
                        end
                        PH_ATYPE: begin
                            n_shift = {n_shift[23:0], b};
                            n_fpos  = n_fpos + 4'd1;
                            if (n_fpos == 4'd4) begin
                                n_rw = dre_wanted(n_shift[31:16], n_shift[15:0]);
                                if (rem < 16'd6) begin
                                    n_phase = PH_DONE;
                                    n_stat  = ST_TRUNCATED;
                                end else begin
                                    n_phase = PH_ATTL;
                                    n_fpos  = '0;
                                end
                            end
                        end
                        PH_ATTL: begin
                            n_fpos = n_fpos + 4'd1;
                            if (n_fpos == 4'd4) begin
                                n_phase = PH_ARDLEN;
                                n_fpos  = '0;
                                n_shift = '0;
                            end
                        end
                        PH_ARDLEN: begin
                            n_shift = {n_shift[23:0], b};
                            n_fpos  = n_fpos + 4'd1;
                            if (n_fpos == 4'd2) begin
                                rdlen = n_shift[15:0];
                                n_ans = n_ans - 16'd1;
                                if (n_rw && rdlen == 16'd4) begin
                                    if (rem < 16'd4) begin
                                        n_phase = PH_DONE;
                                        n_stat  = ST_TRUNCATED;
                                    end else begin
                                        n_phase = PH_ADDR;
                                        n_fpos  = '0;
                                        n_shift = '0;
                                    end
                                end else if (n_ans == 16'd0) begin
                                    n_phase = PH_DONE;
                                    n_stat  = ST_COMPLETE;
                                end else if (rdlen >= rem) begin
                                    n_phase = PH_DONE;
                                    n_stat  = ST_TRUNCATED;
                                end else if (rdlen == 16'd0) begin
                                    n_fpos  = 4'd1;
                                    if (rem > r_cfg_window) begin
                                        n_phase = PH_DONE;
                                        n_stat  = ST_TRUNCATED;
                                    end else begin
                                        n_phase = PH_NAME_LEN;
                                    end
                                end else begin
                                    n_rd    = rdlen;
                                    n_phase = PH_SKIP;
                                end
                            end
                        end
                        PH_ADDR: begin
                            n_shift = {n_shift[23:0], b};
                            n_fpos  = n_fpos + 4'd1;
                            if (n_fpos == 4'd4) begin
                                rec_v      = 1'b1;
                                rec_server = n_shift;
                                if (n_ans == 16'd0) begin
                                    n_phase = PH_DONE;
                                    n_stat  = ST_COMPLETE;
                                end else begin
                                    n_fpos = 4'd1;
                                    if (rem == 16'd0 || rem > r_cfg_window) begin
                                        n_phase = PH_DONE;
                                        n_stat  = ST_TRUNCATED;
                                    end else begin
                                        n_phase = PH_NAME_LEN;
                                    end
                                end
                            end
                        end
                        PH_SKIP: begin
                            n_rd = n_rd - 16'd1;
                            if (n_rd == 16'd0) begin
                                n_fpos = 4'd1;
                                if (rem == 16'd0 || rem > r_cfg_window) begin
                                    n_phase = PH_DONE;
                                    n_stat  = ST_TRUNCATED;
                                end else begin
                                    n_phase = PH_NAME_LEN;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (i_item.last_byte) begin
                st_v    = 1'b1;
                st_code = (n_phase == PH_DONE) ? n_stat : ST_TRUNCATED;
                n_phase = PH_IDLE;
            end
        end
    end

    always_comb begin
        o_results.rec_valid               = rec_v;
        o_results.status_valid            = st_v;
        o_results.rec.result_kind         = KIND_RECORD;
        o_results.rec.client_out          = n_client;
        o_results.rec.server_address      = rec_server;
        o_results.rec.end_status          = ST_COMPLETE;
        o_results.rec.last_result         = !st_v;
        o_results.status.result_kind      = KIND_STATUS;
        o_results.status.client_out       = n_client;
        o_results.status.server_address   = '0;
        o_results.status.end_status       = st_code;
        o_results.status.last_result      = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_brem   <= '0;
            r_fpos   <= '0;
            r_lab    <= '0;
            r_ans    <= '0;
            r_rd     <= '0;
            r_shift  <= '0;
            r_client <= '0;
            r_rw     <= 1'b0;
            r_stat   <= ST_COMPLETE;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_brem   <= n_brem;
            r_fpos   <= n_fpos;
            r_lab    <= n_lab;
            r_ans    <= n_ans;
            r_rd     <= n_rd;
            r_shift  <= n_shift;
            r_client <= n_client;
            r_rw     <= n_rw;
            r_stat   <= n_stat;
        end
    end

    `DRE_ASSERT(a_status_ends_packet, i_clk, i_rst_n, (i_step && st_v) |=> (r_phase == PH_IDLE), "status beat left packet open")
    `DRE_ASSERT(a_record_from_addr, i_clk, i_rst_n, (i_step && rec_v) |-> (r_phase == PH_ADDR && !i_item.first_byte), "record outside address field")

endmodule

@@ sv/dre_result_fifo.sv @@
// Result queue: takes up to two result beats per cycle, hands out one.
// Uses dre_pkg for the result types and depth.
`include "assert_macros.svh"
module dre_result_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  dre_pkg::t_result_pair  i_results,
    output logic                   o_space,
    output logic                   o_valid,
    output dre_pkg::t_result       o_result,
    input  logic                   i_pop
);
    import dre_pkg::*;

    t_result               mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]  r_wr, r_rd;
    logic [RES_CNT_W-1:0]  r_count, n_count;
    logic                  push0, push1, pop;
    t_result               w0;
    logic [RES_CNT_W-1:0]  push_n;

    assign push0   = i_push && (i_results.rec_valid || i_results.status_valid);
    assign push1   = i_push && i_results.rec_valid && i_results.status_valid;
    assign w0      = i_results.rec_valid ? i_results.rec : i_results.status;
    assign pop     = i_pop && o_valid;
    assign push_n  = RES_CNT_W'(push0) + RES_CNT_W'(push1);
    assign n_count = r_count + push_n - RES_CNT_W'(pop);

    assign o_space  = (r_count <= RES_CNT_W'(RES_DEPTH - 2));
    assign o_valid  = (r_count != '0);
    assign o_result = mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push0) mem[r_wr] <= w0;
        if (push1) mem[r_wr + RES_PTR_W'(1)] <= i_results.status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + push_n[RES_PTR_W-1:0];
            r_rd    <= r_rd + RES_PTR_W'(pop);
            r_count <= n_count;
        end
    end

    `DRE_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> o_space, "push into full result queue")
    `DRE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= RES_CNT_W'(RES_DEPTH), "result count out of range")

endmodule

@@ sv/dns_response_address_extractor_top.sv @@
// DNS response address extractor: takes one payload byte per beat and
// returns an address record beat for each usable A or MX answer and a
// status beat on the last byte of a packet. Each byte is registered, then
// parsed in one pass; results go through a four-entry queue, so a byte is
// accepted every cycle while the output keeps pace, each byte giving at
// most two result beats. Depends on dre_pkg, dre_parser and
// dre_result_fifo.
`include "assert_macros.svh"
module dns_response_address_extractor_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dre_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]                    i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // data_byte[7:0], payload_length[23:8], source_port[39:24],
    // client_address[71:40]
    input  logic [71:0]                    s_axis_tdata,
    // first_byte
    input  logic                           s_axis_tuser,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // client_out[31:0], server_address[63:32], end_status[66:64], zero[71:67]
    output logic [71:0]                    m_axis_tdata,
    // result_kind
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);
    import dre_pkg::*;

    logic          r_in_valid;
    t_item         r_in;
    logic          step;
    logic          space;
    t_result_pair  results;
    t_result       head;

    assign step          = r_in_valid && space;
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.data_byte      <= s_axis_tdata[7:0];
            r_in.payload_length <= s_axis_tdata[23:8];
            r_in.source_port    <= s_axis_tdata[39:24];
            r_in.client_address <= s_axis_tdata[71:40];
            r_in.first_byte     <= s_axis_tuser;
            r_in.last_byte      <= s_axis_tlast;
        end
    end

    dre_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (step),
        .i_item      (r_in),
        .o_results   (results)
    );

    dre_result_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (step),
        .i_results (results),
        .o_space   (space),
        .o_valid   (m_axis_tvalid),
        .o_result  (head),
        .i_pop     (m_axis_tready)
    );

    assign m_axis_tdata = {5'd0, head.end_status, head.server_address, head.client_out};
    assign m_axis_tuser = head.result_kind;
    assign m_axis_tlast = head.last_result;

    `DRE_ASSERT(a_stalled_item_held, i_clk, i_rst_n, (r_in_valid && !space) |=> r_in_valid, "stalled byte lost")

endmodule
